FILE: design/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean filter
// Window geometry, store layout, widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int WINDOW_SIDE = 21;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;

  localparam int HALF_SIDE  = WINDOW_SIDE / 2;
  localparam int MIN_SIDE   = 2 * HALF_SIDE + 1;
  localparam int LINE_SLOTS = 2 * HALF_SIDE + 2;
  localparam int TAP_COUNT  = WINDOW_SIDE * WINDOW_SIDE;
  localparam int SUM_TAPS   = MIN_SIDE * MIN_SIDE;
  localparam int HALF_TAPS  = TAP_COUNT / 2;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLOT_W  = $clog2(LINE_SLOTS);
  localparam int TAP_W   = $clog2(MIN_SIDE);
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int DEPTH   = LINE_SLOTS * MAX_WIDTH;
  localparam int ACC_W   = $clog2(SUM_TAPS * 255 + 1);

  // The rounded mean (sum + HALF_TAPS) / TAP_COUNT is taken as a multiply by
  // a rounded-up reciprocal; the shift is wide enough to make it exact for
  // every dividend that fits in SUM_W bits.
  localparam int SUM_W       = ACC_W + 1;
  localparam int RECIP_SHIFT = SUM_W + $clog2(TAP_COUNT);
  localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + TAP_COUNT - 1) / TAP_COUNT;
  localparam int M_W         = SUM_W + 2;
  localparam int PROD_W      = SUM_W + M_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  localparam int FW_W    = 11;
  localparam int FH_W    = 13;
  localparam int CFG_W   = 13;
  localparam int PIX_W   = 8;

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic accept;
    logic sum_step;
    logic mul_load;
    logic out_load;
  } bmf_cmd_t;

  typedef struct packed {
    logic emit_go;
    logic tap_last;
    logic out_free;
  } bmf_status_t;

endpackage

FILE: design/box_mean_filter_mirror_2d_top.sv
// ----------------------------------------------------------------------------
// box_mean_filter_mirror_2d_top: 21x21 box mean filter with centre mirroring
// Streaming grey-image filter built from a controller and a datapath.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the slave stream and each output is the
// rounded mean of the 21x21 window around a pixel, (sum + 220) / 441, with
// window offsets that leave the frame mirrored about the centre pixel. An
// output appears once its input has run 10 rows plus 10 pixels ahead; after
// the last pixel of a frame, drain transactions (tuser high) release the
// remaining outputs one per transaction, and a drain with nothing owed gives
// no output. A transaction that produces no output leaves the block idle.
// One that produces an output keeps the block busy after it is taken: the
// window is summed through the single read port of the line store at one
// tap per cycle, then a flush state drains the read pipeline, a multiply
// state forms the mean with a reciprocal multiply and an output state loads
// the output register; the result is valid in the cycle after that load and
// the next transaction is taken once the block is idle again. The output
// register lets the next transaction be taken while a result still waits on
// the master side; the load stalls only while an earlier result is unread.
// Writing either size register restarts the frame; write only while the block
// is idle. The line store is not cleared after reset, since every window entry
// is written before use.
// ----------------------------------------------------------------------------
module box_mean_filter_mirror_2d_top import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic              cfg_index,   // 0: frame_width, 1: frame_height
  input  logic [CFG_W-1:0]  cfg_data,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,     // [7:0] pixel_in
  input  logic              s_tuser,     // [0] req_type
  // Output stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,     // [7:0] pixel_out
  output logic              m_tlast      // last_of_frame
);

  bmf_cmd_t    cmd;
  bmf_status_t status;

  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bmf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (s_tuser),
    .pixel_in      (s_tdata),
    .cmd           (cmd),
    .status        (status),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .pixel_out     (m_tdata),
    .last_of_frame (m_tlast)
  );

endmodule

FILE: design/bmf_ctrl.sv
// ----------------------------------------------------------------------------
// bmf_ctrl: sequencing state machine
// Steps one item through intake, window summation, division and output.
// ----------------------------------------------------------------------------
module bmf_ctrl import bmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  bmf_status_t status,
  output bmf_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_FLUSH = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid && status.emit_go) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.tap_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath: line store, window address generation, accumulator, divider
// Holds frame positions and size registers and the output register.
// ----------------------------------------------------------------------------
module bmf_datapath import bmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              req_type,
  input  logic [PIX_W-1:0]  pixel_in,
  input  bmf_cmd_t          cmd,
  output bmf_status_t       status,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              last_of_frame
);

  localparam int RS_W = ROW_W + 2;
  localparam int CS_W = COL_W + 2;
  localparam int DS_W = SLOT_W + 2;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [FW_W-1:0]   eff_w;
  logic [FH_W-1:0]   eff_h;

  logic [ROW_W-1:0]  in_row, out_row;
  logic [COL_W-1:0]  in_col, out_col;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic              in_done;

  logic [TAP_W-1:0]  tap_r, tap_c;
  logic [ACC_W-1:0]  acc;
  logic              rd_vld;
  logic [PIX_W-1:0]  rdata;
  logic [PIX_W-1:0]  mem [0:DEPTH-1];

  logic [SUM_W-1:0]  rnd_sum;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic              sat;

  logic              is_pixel, ready_pos, last_pos;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  // Effective frame size, clamped to the supported range.
  always_comb begin
    eff_w = frame_width;
    if (frame_width < FW_W'(MIN_SIDE)) eff_w = FW_W'(MIN_SIDE);
    if (frame_width > FW_W'(MAX_WIDTH)) eff_w = FW_W'(MAX_WIDTH);
    eff_h = frame_height;
    if (frame_height < FH_W'(MIN_SIDE)) eff_h = FH_W'(MIN_SIDE);
    if (frame_height > FH_W'(MAX_HEIGHT)) eff_h = FH_W'(MAX_HEIGHT);
  end

  assign is_pixel  = (req_type == REQ_PIXEL) && !in_done;
  assign ready_pos = (in_row > ROW_W'(HALF_SIDE)) ||
                     ((in_row == ROW_W'(HALF_SIDE)) && (in_col >= COL_W'(HALF_SIDE)));
  assign last_pos  = ({1'b0, out_row} == eff_h - FH_W'(1)) &&
                     ({1'b0, out_col} == eff_w - FW_W'(1));

  assign status.emit_go  = in_done || (is_pixel && ready_pos);
  assign status.tap_last = (tap_r == TAP_W'(MIN_SIDE - 1)) && (tap_c == TAP_W'(MIN_SIDE - 1));
  assign status.out_free = !m_tvalid || m_tready;

  // Window tap address, mirrored about the centre pixel.
  logic signed [RS_W-1:0] r_c, kr, dr;
  logic signed [CS_W-1:0] c_c, kc;
  logic signed [DS_W-1:0] slot_s;

  always_comb begin
    r_c = signed'({2'b00, out_row});
    kr  = r_c + signed'(RS_W'(tap_r)) - signed'(RS_W'(HALF_SIDE));
    if (kr < 0 || kr >= signed'(RS_W'(eff_h))) kr = (r_c <<< 1) - kr;
    if (kr < 0) kr = '0;
    if (kr >= signed'(RS_W'(eff_h))) kr = signed'(RS_W'(eff_h)) - signed'(RS_W'(1));
    dr     = kr - r_c;
    slot_s = signed'(DS_W'(out_slot)) + signed'(dr[DS_W-1:0]);
    if (slot_s < 0) begin
      slot_s = slot_s + signed'(DS_W'(LINE_SLOTS));
    end else if (slot_s >= signed'(DS_W'(LINE_SLOTS))) begin
      slot_s = slot_s - signed'(DS_W'(LINE_SLOTS));
    end

    c_c = signed'({2'b00, out_col});
    kc  = c_c + signed'(CS_W'(tap_c)) - signed'(CS_W'(HALF_SIDE));
    if (kc < 0 || kc >= signed'(CS_W'(eff_w))) kc = (c_c <<< 1) - kc;
    if (kc < 0) kc = '0;
    if (kc >= signed'(CS_W'(eff_w))) kc = signed'(CS_W'(eff_w)) - signed'(CS_W'(1));
  end

  assign rd_addr = {slot_s[SLOT_W-1:0], kc[COL_W-1:0]};
  assign wr_addr = {in_slot, in_col};

  // Line store: one write port for intake, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept && is_pixel) begin
      mem[wr_addr] <= pixel_in;
    end
    rdata <= mem[rd_addr];
  end

  // Size registers and raster positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
      in_done  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[FW_W-1:0];
      end else begin
        frame_height <= cfg_data[FH_W-1:0];
      end
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
      in_done  <= 1'b0;
    end else begin
      if (cmd.accept && is_pixel) begin
        if ({1'b0, in_col} + FW_W'(1) >= eff_w) begin
          in_col <= '0;
          if ({1'b0, in_row} + FH_W'(1) >= eff_h) begin
            in_row  <= '0;
            in_slot <= '0;
            in_done <= 1'b1;
          end else begin
            in_row  <= in_row + ROW_W'(1);
            in_slot <= (in_slot == SLOT_W'(LINE_SLOTS - 1)) ? '0 : in_slot + SLOT_W'(1);
          end
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (cmd.out_load) begin
        if (last_pos) begin
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
          in_done  <= 1'b0;
        end else if ({1'b0, out_col} + FW_W'(1) >= eff_w) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_slot <= (out_slot == SLOT_W'(LINE_SLOTS - 1)) ? '0 : out_slot + SLOT_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // Tap counters and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_r  <= '0;
      tap_c  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.sum_step;
      if (cmd.accept) begin
        tap_r <= '0;
        tap_c <= '0;
      end else if (cmd.sum_step) begin
        if (tap_c == TAP_W'(MIN_SIDE - 1)) begin
          tap_c <= '0;
          tap_r <= tap_r + TAP_W'(1);
        end else begin
          tap_c <= tap_c + TAP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc <= '0;
    end else if (rd_vld) begin
      acc <= acc + ACC_W'(rdata);
    end
  end

  // Rounded mean by reciprocal multiplication; the product is registered.
  assign rnd_sum = SUM_W'(acc) + SUM_W'(HALF_TAPS);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= PROD_W'(rnd_sum) * PROD_W'(RECIP_MUL);
    end
  end

  assign quo = prod[PROD_W-1:RECIP_SHIFT];
  assign sat = |quo[QUO_W-1:PIX_W];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_out     <= sat ? '1 : quo[PIX_W-1:0];
      last_of_frame <= last_pos;
    end
  end

endmodule

FILE: design/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker: port-level checks for the box mean filter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module bmf_checker import bmf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("output appeared without a busy period");

  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("output appeared right after intake");

endmodule

bind box_mean_filter_mirror_2d_top bmf_checker u_bmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
